// ===== hw/rtl/fcca_pkg.sv =====
// Package with the shared types and constants of the cluster chain allocator.
`default_nettype none
package fcca_pkg;

  localparam int CLUSTER_BYTES_DEF = 1024;
  localparam int MAP_CLUSTERS_DEF  = 16384;
  localparam int DISK_CLUSTERS_DEF = 10240;

  localparam logic [15:0] END_MARK = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_ALLOC      = 2'd0,
    ACT_FREE_CHAIN = 2'd1,
    ACT_FREE_ONE   = 2'd2,
    ACT_MARK_USED  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADWALK = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CK,
    S_NEXT,
    S_RB_RD,
    S_RB_CK,
    S_FC_RD,
    S_FC_CK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        used_we;
    logic        used_wd;
    logic [15:0] used_wa;
    logic [15:0] used_ra;
    logic        link_we;
    logic [15:0] link_wa;
    logic [15:0] link_wd;
    logic [15:0] link_ra;
  } mem_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] first_cluster;
    logic [14:0] clusters_done;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fcca_store.sv =====
// Used-cluster bitmap and next-cluster link memories with registered reads.
`default_nettype none
module fcca_store #(
  parameter int MAP_CLUSTERS = fcca_pkg::MAP_CLUSTERS_DEF
) (
  input  wire logic               clk,
  input  wire fcca_pkg::mem_req_t req,
  output logic                    used_rd,
  output logic [15:0]             link_rd
);
  import fcca_pkg::*;

  localparam int AW = $clog2(MAP_CLUSTERS);

  logic        used_mem [0:MAP_CLUSTERS-1];
  logic [15:0] link_mem [0:MAP_CLUSTERS-1];

  always_ff @(posedge clk) begin
    if (req.used_we) begin
      used_mem[req.used_wa[AW-1:0]] <= req.used_wd;
    end
    used_rd <= used_mem[req.used_ra[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (req.link_we) begin
      link_mem[req.link_wa[AW-1:0]] <= req.link_wd;
    end
    link_rd <= link_mem[req.link_ra[AW-1:0]];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fcca_seq.sv =====
// Sequencer that scans the bitmap, builds, rolls back and frees cluster chains, and sets single bits.
`default_nettype none
module fcca_seq #(
  parameter int CLUSTER_BYTES = fcca_pkg::CLUSTER_BYTES_DEF,
  parameter int MAP_CLUSTERS  = fcca_pkg::MAP_CLUSTERS_DEF,
  parameter int DISK_CLUSTERS = fcca_pkg::DISK_CLUSTERS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire logic [1:0]         req_action,
  input  wire logic [30:0]        req_size,
  input  wire logic [13:0]        req_cluster,
  output fcca_pkg::mem_req_t      mem,
  input  wire logic               used_rd,
  input  wire logic [15:0]        link_rd,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output fcca_pkg::res_t          res
);
  import fcca_pkg::*;

  localparam int PW = $clog2(MAP_CLUSTERS + 1);
  localparam logic [PW-1:0] MAP_N  = PW'(MAP_CLUSTERS);
  localparam logic [PW-1:0] MAP_M1 = PW'(MAP_CLUSTERS - 1);
  localparam logic [32:0] CAP = 33'(CLUSTER_BYTES) * 33'(DISK_CLUSTERS);
  localparam logic [32:0] CB  = 33'(CLUSTER_BYTES);

  state_t        state_r, state_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] prev_r, prev_nxt;
  logic [PW-1:0] first_r, first_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic [32:0]   acc_r, acc_nxt;
  logic [30:0]   size_r, size_nxt;
  logic          have_r, have_nxt;
  res_t          res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r  <= prev_nxt;
    first_r <= first_nxt;
    cnt_r   <= cnt_nxt;
    acc_r   <= acc_nxt;
    size_r  <= size_nxt;
    have_r  <= have_nxt;
    res_r   <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    prev_nxt  = prev_r;
    first_nxt = first_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    size_nxt  = size_r;
    have_nxt  = have_r;
    res_nxt   = res_r;
    mem       = '0;
    req_ready = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mem.used_we = 1'b1;
        mem.used_wa = 16'(pos_r);
        mem.link_we = 1'b1;
        mem.link_wa = 16'(pos_r);
        pos_nxt     = PW'(pos_r + 1'b1);
        if (pos_r == MAP_M1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          size_nxt = req_size;
          cnt_nxt  = '0;
          unique case (req_action)
            ACT_ALLOC: begin
              have_nxt  = 1'b0;
              pos_nxt   = '0;
              state_nxt = S_SCAN_RD;
            end
            ACT_FREE_CHAIN: begin
              if (17'(req_cluster) < 17'(MAP_CLUSTERS)) begin
                pos_nxt   = PW'(req_cluster);
                state_nxt = S_FC_RD;
              end else begin
                res_nxt   = '{ST_BADWALK, 14'd0, 15'd0};
                state_nxt = S_DONE;
              end
            end
            default: begin
              if (17'(req_cluster) < 17'(MAP_CLUSTERS)) begin
                mem.used_we = 1'b1;
                mem.used_wa = 16'(req_cluster);
                mem.used_wd = (req_action == ACT_MARK_USED);
                res_nxt     = '{ST_OK, 14'd0, 15'd1};
              end else begin
                res_nxt     = '{ST_OK, 14'd0, 15'd0};
              end
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        if (pos_r == MAP_N) begin
          if (have_r) begin
            pos_nxt   = first_r;
            state_nxt = S_RB_RD;
          end else begin
            res_nxt   = '{ST_NOSPACE, 14'd0, 15'd0};
            state_nxt = S_DONE;
          end
        end else begin
          mem.used_ra = 16'(pos_r);
          state_nxt   = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        if (used_rd) begin
          pos_nxt   = PW'(pos_r + 1'b1);
          state_nxt = S_SCAN_RD;
        end else begin
          mem.used_we = 1'b1;
          mem.used_wa = 16'(pos_r);
          mem.used_wd = 1'b1;
          prev_nxt    = pos_r;
          if (!have_r) begin
            have_nxt  = 1'b1;
            first_nxt = pos_r;
            cnt_nxt   = PW'(1);
            acc_nxt   = CB;
            if (size_r == 31'd0 || {2'b00, size_r} >= CAP) begin
              res_nxt   = '{ST_OK, 14'(pos_r), 15'd1};
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_NEXT;
            end
          end else begin
            mem.link_we = 1'b1;
            mem.link_wa = 16'(prev_r);
            mem.link_wd = 16'(pos_r);
            cnt_nxt     = PW'(cnt_r + 1'b1);
            acc_nxt     = 33'(acc_r + CB);
            state_nxt   = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        if (acc_r < {2'b00, size_r}) begin
          pos_nxt   = PW'(prev_r + 1'b1);
          state_nxt = S_SCAN_RD;
        end else begin
          mem.link_we = 1'b1;
          mem.link_wa = 16'(prev_r);
          mem.link_wd = END_MARK;
          res_nxt     = '{ST_OK, 14'(first_r), 15'(cnt_r)};
          state_nxt   = S_DONE;
        end
      end
      S_RB_RD: begin
        mem.used_we = 1'b1;
        mem.used_wa = 16'(pos_r);
        mem.link_ra = 16'(pos_r);
        acc_nxt     = 33'(acc_r - CB);
        prev_nxt    = PW'(prev_r + 1'b1);
        state_nxt   = S_RB_CK;
      end
      S_RB_CK: begin
        if (PW'(prev_r) == cnt_r) begin
          res_nxt   = '{ST_NOSPACE, 14'd0, 15'(cnt_r)};
          state_nxt = S_DONE;
        end else begin
          pos_nxt   = PW'(link_rd);
          state_nxt = S_RB_RD;
        end
      end
      S_FC_RD: begin
        if (cnt_r == MAP_N) begin
          res_nxt   = '{ST_BADWALK, 14'd0, 15'(cnt_r)};
          state_nxt = S_DONE;
        end else begin
          mem.used_we = 1'b1;
          mem.used_wa = 16'(pos_r);
          mem.link_ra = 16'(pos_r);
          cnt_nxt     = PW'(cnt_r + 1'b1);
          state_nxt   = S_FC_CK;
        end
      end
      S_FC_CK: begin
        if (link_rd == END_MARK) begin
          res_nxt   = '{ST_OK, 14'd0, 15'(cnt_r)};
          state_nxt = S_DONE;
        end else if (17'(link_rd) >= 17'(MAP_CLUSTERS)) begin
          res_nxt   = '{ST_BADWALK, 14'd0, 15'(cnt_r)};
          state_nxt = S_DONE;
        end else begin
          pos_nxt   = PW'(link_rd);
          state_nxt = S_FC_RD;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (state_r == S_SCAN_RD && pos_r == MAP_N && have_r) begin
      prev_nxt = '0;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ===== hw/rtl/fat_cluster_chain_allocator.sv =====
// Top level of the cluster chain allocator with its output register.
//
// Requests arrive on the in_ stream: in_tuser carries the action (allocate,
// free chain, free one, mark used), in_tdata the byte size and the cluster.
// One result per request leaves on the out_ stream: out_tuser is the status,
// out_tdata the first cluster of a new chain and the count of clusters
// claimed or released.
// After reset a clearing pass over every cluster zeroes the bitmap and
// the link table; in_tready stays low until it is over.
// A request is taken only while the sequencer is idle. Free one and mark
// used write the bitmap bit as the request is taken. Allocation probes
// one bitmap bit at a time through the single bitmap read port, from
// cluster 0 up, and links each free cluster it claims to the last one;
// if the bitmap runs out, a rollback frees the claimed clusters again.
// Freeing a chain follows the links and clears each bit up to the end mark.
// The result waits in the output register while the receiver stalls; the
// sequencer holds its next result until that register is free.
`default_nettype none
module fat_cluster_chain_allocator #(
  parameter int CLUSTER_BYTES = fcca_pkg::CLUSTER_BYTES_DEF,
  parameter int MAP_CLUSTERS  = fcca_pkg::MAP_CLUSTERS_DEF,
  parameter int DISK_CLUSTERS = fcca_pkg::DISK_CLUSTERS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // size_bytes[30:0], cluster[44:31], zero
  input  wire logic [1:0]  in_tuser,  // action[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata, // first_cluster[13:0], clusters_done[28:14], zero
  output logic [1:0]       out_tuser  // status[1:0]
);
  import fcca_pkg::*;

  mem_req_t    mem;
  logic        used_rd;
  logic [15:0] link_rd;
  logic        res_valid, res_ready;
  res_t        res;
  logic        out_valid_r;
  res_t        out_r;

  fcca_seq #(
    .CLUSTER_BYTES(CLUSTER_BYTES),
    .MAP_CLUSTERS (MAP_CLUSTERS),
    .DISK_CLUSTERS(DISK_CLUSTERS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_action (in_tuser),
    .req_size   (in_tdata[30:0]),
    .req_cluster(in_tdata[44:31]),
    .mem        (mem),
    .used_rd    (used_rd),
    .link_rd    (link_rd),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  fcca_store #(
    .MAP_CLUSTERS(MAP_CLUSTERS)
  ) u_store (
    .clk    (clk),
    .req    (mem),
    .used_rd(used_rd),
    .link_rd(link_rd)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {3'b000, out_r.clusters_done, out_r.first_cluster};

endmodule
`default_nettype wire

// ===== hw/rtl/fcca_checker.sv =====
// Port-level checker of the cluster chain allocator and its bind statement.
`default_nettype none
module fcca_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser
);
  import fcca_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid && !in_tready)
    else $error("Ports active straight after reset.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("A second request was taken without a pause.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("Result carries an undefined status.");

  a_first_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata[13:0] == 14'd0)
    else $error("Failed request reports a first cluster.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Stalled result changed.");

endmodule

bind fat_cluster_chain_allocator fcca_checker u_fcca_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
`default_nettype wire
